FILE: sv/deferred_free_descriptor_allocator_defines.svh
// assertion macros shared by the allocator modules
// expects aclk and aresetn in the scope of each use
`ifndef DEFERRED_FREE_DESCRIPTOR_ALLOCATOR_DEFINES_SVH
`define DEFERRED_FREE_DESCRIPTOR_ALLOCATOR_DEFINES_SVH

// consequent checked in the same cycle
`define DFDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define DFDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dfda_pkg.sv
// shared constants, codes and controller/datapath interface structs
// no dependencies
package dfda_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int NUM_FRAMES  = 3;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int ADDR_W      = 48;
    localparam int STRIDE_W    = 13;
    localparam int OFFS_W      = IDX_W + STRIDE_W;
    localparam int CMD_W       = 2;
    localparam int FRAME_W     = 2;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CNT_W-1:0]    RST_SLOT_COUNT  = 7'd64;
    localparam logic [STRIDE_W-1:0] RST_SLOT_STRIDE = 13'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_PROCESS = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_BAD_ADDR    = 3'd2,
        ST_NONE_IN_USE = 3'd3,
        ST_IGNORED     = 3'd4,
        ST_FRAME_FULL  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_COUNT     = 3'd0,
        CFG_SLOT_STRIDE    = 3'd1,
        CFG_CPU_BASE       = 3'd2,
        CFG_GPU_BASE       = 3'd3,
        CFG_SHADER_VISIBLE = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic    capture;
        logic    fs_read;
        logic    alloc_mul;
        logic    alloc_add;
        logic    free_mul;
        logic    free_add;
        logic    park;
        logic    walk_start;
        logic    pk_read;
        logic    push;
        logic    walk_clear;
        logic    out_load;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             addr_zero;
        logic             none_in_use;
        logic             addr_bad;
        logic             frame_bad;
        logic             frame_full;
        logic             walk_more;
        logic             out_free;
    } dp_stat_t;

endpackage

FILE: sv/deferred_free_descriptor_allocator.sv
// top level of the deferred-free descriptor slot allocator
// depends on dfda_pkg, dfda_ctrl and dfda_datapath
//
//   channel   handshake          beat contents
//   s_        s_valid/s_ready    command, slot address, claimed index, frame
//   m_        m_valid/m_ready    status, slot index, cpu/gpu address, slots in use
//   cfg_      cfg_write          register index and data, no read-back
//
// allocate and every free run from accept to accept through the decode or stack
// read, the index-times-stride multiply and the 48-bit add/compare after it.
// a full allocate, an unknown command or a process of an out-of-range frame goes
// from decode straight to the finish state; processing a frame reads and pushes
// back its parked entries in turn. no clearing pass: ready once aresetn goes high.
// a result waits in the output register while the next beat is accepted; the
// following result stalls until m_ready frees that register.
module deferred_free_descriptor_allocator #(
    parameter int FrameCount = dfda_pkg::NUM_FRAMES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_write,
    input  logic [dfda_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfda_pkg::ADDR_W-1:0]       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dfda_pkg::CMD_W-1:0]        s_command,
    input  logic [dfda_pkg::ADDR_W-1:0]       s_slot_address,
    input  logic [dfda_pkg::IDX_W-1:0]        s_claimed_index,
    input  logic [dfda_pkg::FRAME_W-1:0]      s_frame_number,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dfda_pkg::STATUS_W-1:0]     m_status,
    output logic [dfda_pkg::IDX_W-1:0]        m_slot_index,
    output logic [dfda_pkg::ADDR_W-1:0]       m_cpu_address,
    output logic [dfda_pkg::ADDR_W-1:0]       m_gpu_address,
    output logic [dfda_pkg::CNT_W-1:0]        m_slots_in_use
);

    dfda_pkg::dp_cmd_t  dp_cmd;
    dfda_pkg::dp_stat_t dp_stat;

    dfda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    dfda_datapath #(
        .FrameCount (FrameCount)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_command       (s_command),
        .s_slot_address  (s_slot_address),
        .s_claimed_index (s_claimed_index),
        .s_frame_number  (s_frame_number),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot_index    (m_slot_index),
        .m_cpu_address   (m_cpu_address),
        .m_gpu_address   (m_gpu_address),
        .m_slots_in_use  (m_slots_in_use)
    );

endmodule

FILE: sv/dfda_ctrl.sv
// sequencing state machine of the allocator
// depends on dfda_pkg and the assertion macro header
`include "deferred_free_descriptor_allocator_defines.svh"

module dfda_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dfda_pkg::dp_stat_t stat,
    output dfda_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_FREE_ADD,
        S_FREE_CHK,
        S_PROC_RD,
        S_PROC_WR,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    dfda_pkg::status_t   st_reg, st_next;

    always_comb begin
        cmd        = '0;
        cmd.status = st_reg;
        s_ready    = 1'b0;
        state_next = state_reg;
        st_next    = st_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (dfda_pkg::cmd_t'(stat.cmd))
                    dfda_pkg::CMD_ALLOC: begin
                        if (stat.full) begin
                            st_next    = dfda_pkg::ST_FULL;
                            state_next = S_FINISH;
                        end else begin
                            cmd.fs_read = 1'b1;
                            state_next  = S_ALLOC_MUL;
                        end
                    end
                    dfda_pkg::CMD_FREE: begin
                        cmd.free_mul = 1'b1;
                        state_next   = S_FREE_ADD;
                    end
                    dfda_pkg::CMD_PROCESS: begin
                        if (stat.frame_bad) begin
                            st_next    = dfda_pkg::ST_IGNORED;
                            state_next = S_FINISH;
                        end else begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_PROC_RD;
                        end
                    end
                    default: begin
                        st_next    = dfda_pkg::ST_IGNORED;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_ALLOC_MUL: begin
                cmd.alloc_mul = 1'b1;
                state_next    = S_ALLOC_ADD;
            end
            S_ALLOC_ADD: begin
                cmd.alloc_add = 1'b1;
                st_next       = dfda_pkg::ST_OK;
                state_next    = S_FINISH;
            end
            S_FREE_ADD: begin
                cmd.free_add = 1'b1;
                state_next   = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                // check order matters: first failing check names the status
                if (stat.addr_zero) begin
                    st_next = dfda_pkg::ST_IGNORED;
                end else if (stat.none_in_use) begin
                    st_next = dfda_pkg::ST_NONE_IN_USE;
                end else if (stat.addr_bad) begin
                    st_next = dfda_pkg::ST_BAD_ADDR;
                end else if (stat.frame_bad) begin
                    st_next = dfda_pkg::ST_IGNORED;
                end else if (stat.frame_full) begin
                    st_next = dfda_pkg::ST_FRAME_FULL;
                end else begin
                    cmd.park = 1'b1;
                    st_next  = dfda_pkg::ST_OK;
                end
                state_next = S_FINISH;
            end
            S_PROC_RD: begin
                if (stat.walk_more) begin
                    cmd.pk_read = 1'b1;
                    state_next  = S_PROC_WR;
                end else begin
                    // list is emptied even if parked entries were dropped
                    cmd.walk_clear = 1'b1;
                    st_next        = dfda_pkg::ST_OK;
                    state_next     = S_FINISH;
                end
            end
            S_PROC_WR: begin
                cmd.push   = 1'b1;
                state_next = S_PROC_RD;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        cmd.capture = 1'b1;
                        state_next  = S_DECODE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= dfda_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    `DFDA_ASSERT_NOW(a_load_into_free_slot, cmd.out_load, stat.out_free, "result loaded over unread beat")
    `DFDA_ASSERT_NOW(a_push_after_read, cmd.push, $past(cmd.pk_read), "push without parked read")
    `DFDA_ASSERT_NOW(a_mul_after_read, cmd.alloc_mul, $past(cmd.fs_read), "alloc multiply without stack read")

endmodule

FILE: sv/dfda_datapath.sv
// registers, free stack and parked lists, address arithmetic and result register
// depends on dfda_pkg and the assertion macro header
`include "deferred_free_descriptor_allocator_defines.svh"

module dfda_datapath #(
    parameter int FrameCount = dfda_pkg::NUM_FRAMES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_write,
    input  logic [dfda_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dfda_pkg::ADDR_W-1:0]       cfg_data,
    input  logic [dfda_pkg::CMD_W-1:0]        s_command,
    input  logic [dfda_pkg::ADDR_W-1:0]       s_slot_address,
    input  logic [dfda_pkg::IDX_W-1:0]        s_claimed_index,
    input  logic [dfda_pkg::FRAME_W-1:0]      s_frame_number,
    input  dfda_pkg::dp_cmd_t                 cmd,
    output dfda_pkg::dp_stat_t                stat,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dfda_pkg::STATUS_W-1:0]     m_status,
    output logic [dfda_pkg::IDX_W-1:0]        m_slot_index,
    output logic [dfda_pkg::ADDR_W-1:0]       m_cpu_address,
    output logic [dfda_pkg::ADDR_W-1:0]       m_gpu_address,
    output logic [dfda_pkg::CNT_W-1:0]        m_slots_in_use
);

    localparam int FrameW   = (FrameCount > 1) ? $clog2(FrameCount) : 1;
    localparam int CntDepth = 1 << FrameW;
    localparam int PkDepth  = FrameCount * dfda_pkg::MAX_SLOTS;
    localparam int PkAddrW  = $clog2(PkDepth);

    localparam int IW = dfda_pkg::IDX_W;
    localparam int CW = dfda_pkg::CNT_W;
    localparam int AW = dfda_pkg::ADDR_W;
    localparam int SW = dfda_pkg::STRIDE_W;
    localparam int OW = dfda_pkg::OFFS_W;

    // configuration
    logic [CW-1:0] slot_count_reg;
    logic [SW-1:0] slot_stride_reg;
    logic [AW-1:0] cpu_base_reg;
    logic [AW-1:0] gpu_base_reg;
    logic          shader_visible_reg;
    logic [CW-1:0] cap;
    logic [SW-1:0] stride;

    // captured item
    logic [dfda_pkg::CMD_W-1:0]   cmd_reg;
    logic [AW-1:0]                addr_reg;
    logic [IW-1:0]                claimed_reg;
    logic [dfda_pkg::FRAME_W-1:0] frame_reg;
    logic [FrameW-1:0]            frame_sel;
    logic                         frame_bad;

    // allocator state
    logic [CW-1:0]         in_use_reg;
    logic [CW-1:0]         in_use_dec;
    logic [CW-1:0]         pk_cnt_reg [CntDepth];
    logic [CW-1:0]         pk_cnt_sel;
    logic [CW-1:0]         walk_reg;
    logic [dfda_pkg::MAX_SLOTS-1:0] fs_valid_reg;

    // memories and their read registers
    logic [IW-1:0]      fs_mem [dfda_pkg::MAX_SLOTS];
    logic [IW-1:0]      fs_rdata_reg;
    logic [IW-1:0]      fs_raddr_reg;
    logic               fs_hit_reg;
    logic [IW-1:0]      fs_word;
    logic [IW-1:0]      fs_rd_addr;
    logic [IW-1:0]      fs_wr_addr;
    logic [IW-1:0]      pk_mem [PkDepth];
    logic [IW-1:0]      pk_rdata_reg;
    logic [PkAddrW-1:0] pk_wr_addr;
    logic [PkAddrW-1:0] pk_rd_addr;

    // arithmetic and result
    logic [OW-1:0] mul_reg;
    logic [AW:0]   sum_reg;
    logic [IW-1:0] res_idx_reg;
    logic [AW-1:0] res_cpu_reg;
    logic [AW-1:0] res_gpu_reg;

    logic                       m_valid_reg;
    logic [dfda_pkg::STATUS_W-1:0] m_status_reg;
    logic [IW-1:0]              m_slot_index_reg;
    logic [AW-1:0]              m_cpu_address_reg;
    logic [AW-1:0]              m_gpu_address_reg;
    logic [CW-1:0]              m_slots_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg     <= dfda_pkg::RST_SLOT_COUNT;
            slot_stride_reg    <= dfda_pkg::RST_SLOT_STRIDE;
            cpu_base_reg       <= '0;
            gpu_base_reg       <= '0;
            shader_visible_reg <= 1'b0;
        end else if (cfg_write) begin
            case (dfda_pkg::cfg_reg_t'(cfg_index))
                dfda_pkg::CFG_SLOT_COUNT:     slot_count_reg     <= cfg_data[CW-1:0];
                dfda_pkg::CFG_SLOT_STRIDE:    slot_stride_reg    <= cfg_data[SW-1:0];
                dfda_pkg::CFG_CPU_BASE:       cpu_base_reg       <= cfg_data;
                dfda_pkg::CFG_GPU_BASE:       gpu_base_reg       <= cfg_data;
                dfda_pkg::CFG_SHADER_VISIBLE: shader_visible_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // capacity clamps to 1..MAX_SLOTS, zero stride acts as one
    assign cap = (slot_count_reg == '0) ? CW'(1) :
                 (slot_count_reg > CW'(dfda_pkg::MAX_SLOTS)) ? CW'(dfda_pkg::MAX_SLOTS) :
                 slot_count_reg;
    assign stride = (slot_stride_reg == '0) ? SW'(1) : slot_stride_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg     <= s_command;
            addr_reg    <= s_slot_address;
            claimed_reg <= s_claimed_index;
            frame_reg   <= s_frame_number;
        end
    end

    assign frame_sel  = FrameW'(frame_reg);
    assign frame_bad  = (int'(frame_reg) >= FrameCount);
    assign pk_cnt_sel = pk_cnt_reg[frame_sel];
    assign in_use_dec = in_use_reg - CW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg   <= '0;
            walk_reg     <= '0;
            fs_valid_reg <= '0;
            for (int i = 0; i < CntDepth; i++) begin
                pk_cnt_reg[i] <= '0;
            end
        end else begin
            if (cmd.alloc_add) begin
                in_use_reg <= in_use_reg + CW'(1);
            end else if (cmd.push) begin
                in_use_reg <= in_use_dec;
            end
            if (cmd.walk_start) begin
                walk_reg <= '0;
            end else if (cmd.push) begin
                walk_reg <= walk_reg + CW'(1);
            end
            if (cmd.push) begin
                fs_valid_reg[fs_wr_addr] <= 1'b1;
            end
            if (cmd.park) begin
                pk_cnt_reg[frame_sel] <= pk_cnt_sel + CW'(1);
            end else if (cmd.walk_clear) begin
                pk_cnt_reg[frame_sel] <= '0;
            end
        end
    end

    // free stack: an entry never written reads as its own index
    assign fs_rd_addr = in_use_reg[IW-1:0];
    assign fs_wr_addr = in_use_dec[IW-1:0];
    assign fs_word    = fs_hit_reg ? fs_rdata_reg : fs_raddr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.fs_read) begin
            fs_rdata_reg <= fs_mem[fs_rd_addr];
            fs_hit_reg   <= fs_valid_reg[fs_rd_addr];
            fs_raddr_reg <= fs_rd_addr;
        end
        if (cmd.push) begin
            fs_mem[fs_wr_addr] <= pk_rdata_reg;
        end
    end

    assign pk_wr_addr = PkAddrW'({frame_sel, pk_cnt_sel[IW-1:0]});
    assign pk_rd_addr = PkAddrW'({frame_sel, walk_reg[IW-1:0]});

    always_ff @(posedge aclk) begin
        if (cmd.park) begin
            pk_mem[pk_wr_addr] <= claimed_reg;
        end
        if (cmd.pk_read) begin
            pk_rdata_reg <= pk_mem[pk_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_idx_reg <= '0;
            res_cpu_reg <= '0;
            res_gpu_reg <= '0;
        end else begin
            if (cmd.alloc_mul) begin
                res_idx_reg <= fs_word;
            end
            if (cmd.park) begin
                res_idx_reg <= claimed_reg;
            end
            if (cmd.alloc_add) begin
                res_cpu_reg <= cpu_base_reg + AW'(mul_reg);
                res_gpu_reg <= shader_visible_reg ? (gpu_base_reg + AW'(mul_reg)) : '0;
            end
        end
        if (cmd.alloc_mul) begin
            mul_reg <= OW'(fs_word) * OW'(stride);
        end else if (cmd.free_mul) begin
            mul_reg <= OW'(claimed_reg) * OW'(stride);
        end
        // address the claimed index would have, kept one bit wider for the carry
        if (cmd.free_add) begin
            sum_reg <= {1'b0, cpu_base_reg} + (AW + 1)'(mul_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg       <= cmd.status;
            m_slot_index_reg   <= res_idx_reg;
            m_cpu_address_reg  <= res_cpu_reg;
            m_gpu_address_reg  <= res_gpu_reg;
            m_slots_in_use_reg <= in_use_reg;
        end
    end

    always_comb begin
        stat             = '0;
        stat.cmd         = cmd_reg;
        stat.full        = (in_use_reg >= cap);
        stat.addr_zero   = (addr_reg == '0);
        stat.none_in_use = (in_use_reg == '0);
        stat.addr_bad    = (addr_reg < cpu_base_reg) || (CW'(claimed_reg) >= cap) ||
                           ({1'b0, addr_reg} != sum_reg);
        stat.frame_bad   = frame_bad;
        stat.frame_full  = (pk_cnt_sel >= CW'(dfda_pkg::MAX_SLOTS));
        stat.walk_more   = (walk_reg < pk_cnt_sel) && (in_use_reg != '0);
        stat.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_index   = m_slot_index_reg;
    assign m_cpu_address  = m_cpu_address_reg;
    assign m_gpu_address  = m_gpu_address_reg;
    assign m_slots_in_use = m_slots_in_use_reg;

    `DFDA_ASSERT_NOW(a_in_use_bound, 1'b1,
        in_use_reg <= CW'(dfda_pkg::MAX_SLOTS), "in-use count above depth")
    `DFDA_ASSERT_NOW(a_park_has_room, cmd.park,
        pk_cnt_sel < CW'(dfda_pkg::MAX_SLOTS), "park into full list")
    `DFDA_ASSERT_NEXT(a_load_shows_count, cmd.out_load,
        m_valid_reg && (m_slots_in_use_reg == $past(in_use_reg)), "result beat lost count")

endmodule
